/* hdl/fdm_pkg.sv */
// Package of shared types and constants for the feedback delay line with mix.
`timescale 1ns / 1ps
`default_nettype none

package fdm_pkg;

  // Shared multiplier operand and product widths.
  localparam int unsigned A_W = 26;
  localparam int unsigned B_W = 18;
  localparam int unsigned P_W = A_W + B_W;

  // Width of a numerator for the divide-by-255 step, and of its quotient.
  localparam int unsigned V_W = 25;
  localparam int unsigned Q_W = 18;

  // floor(2^24 / 255): reciprocal used for the divide-by-255 step.
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [16:0] RECIP = 17'd65793;

  // Rounded division of a signed value n by 255 is floor((n + 127) / 255).
  // A bias of 255 * 2^16 keeps the numerator positive; 2^16 is taken off the quotient.
  localparam logic [V_W-1:0] RDIV_OFS = 25'd16711807;
  localparam int unsigned RDIV_BIAS = 65536;

  typedef enum logic [2:0] {
    CFG_TIME_KNOB     = 3'd0,
    CFG_FEEDBACK_KNOB = 3'd1,
    CFG_MIX_KNOB      = 3'd2,
    CFG_CLAMP_HIGH    = 3'd3,
    CFG_CLAMP_LOW     = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEN_MUL,
    ST_LEN_DIV,
    ST_LEN_FIX,
    ST_FB_DIV,
    ST_FB_FIX,
    ST_RD,
    ST_TAP,
    ST_WET,
    ST_MIX_MUL,
    ST_MIX_DIV,
    ST_MIX_FIX
  } state_e;

  typedef struct packed {
    logic mul_en;
    logic num_load;
  } mul_ctrl_t;

endpackage

`default_nettype wire

/* hdl/fdm_store.sv */
// Echo sample store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module fdm_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [15:0]   wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/fdm_mul_unit.sv */
// Shared signed multiplier with the correction step of a divide by 255.
`timescale 1ns / 1ps
`default_nettype none

module fdm_mul_unit (
  input  wire logic                              clk_i,
  input  wire fdm_pkg::mul_ctrl_t                ctrl_i,
  input  wire logic signed [fdm_pkg::A_W-1:0]    a_i,
  input  wire logic signed [fdm_pkg::B_W-1:0]    b_i,
  input  wire logic        [fdm_pkg::V_W-1:0]    num_i,
  output logic signed      [fdm_pkg::P_W-1:0]    prod_o,
  output logic             [fdm_pkg::V_W-1:0]    num_o,
  output logic             [fdm_pkg::Q_W-1:0]    quot_o
);

  logic signed [fdm_pkg::P_W-1:0] prod_q;
  logic        [fdm_pkg::V_W-1:0] num_q;
  logic        [fdm_pkg::Q_W-1:0] q0;
  logic        [fdm_pkg::V_W:0]   q0x;
  logic        [fdm_pkg::V_W:0]   rem;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
    if (ctrl_i.num_load) begin
      num_q <= num_i;
    end
  end

  // The reciprocal is rounded down, so the estimate is at most one short.
  always_comb begin
    q0     = prod_q[fdm_pkg::RECIP_SHIFT +: fdm_pkg::Q_W];
    q0x    = (fdm_pkg::V_W + 1)'(q0);
    rem    = {1'b0, num_q} - ((q0x << 8) - q0x);
    quot_o = (rem >= (fdm_pkg::V_W + 1)'(255)) ? q0 + 1'b1 : q0;
  end

  assign prod_o = prod_q;
  assign num_o  = num_q;

endmodule

`default_nettype wire

/* hdl/feedback_delay_line_with_mix.sv */
// Top level of the mono feedback echo with fractional delay and wet/dry mix.
`timescale 1ns / 1ps
`default_nettype none

// Mono echo on signed Q1.15 samples. An item is taken in the idle cycle and then passes
// through eleven sequencer steps, the last of which waits for the output register to be
// free before it writes the result there. Seven of those steps use a single shared
// multiplier (delay length, feedback gain, blend and mix, with each divide by 255 done as
// a reciprocal multiply and a one-step correction), and two of them write and then read
// the echo store through its single port pair. The block takes a new item only once the
// sequencer is back in idle; a finished result waits in the output register, and the
// next item may be taken meanwhile.
// The delay length is MIN_DELAY plus time_knob/255 of the span up to MAX_DELAY, with an
// eight-bit fraction that blends the tap with the previous tap. Each sample plus the fed
// back wet signal is clamped to [clamp_low, clamp_high] before it is stored; if the limits
// are crossed, the upper limit, tested first, wins above it. The store reads as zero after
// reset without any clearing pass: a write pointer and a wrap flag tell which entries hold
// written samples, so the block is ready as soon as reset is released. Configuration is
// written through a plain write port and should only be changed while no item is in progress.
module feedback_delay_line_with_mix #(
  parameter int unsigned MAX_DELAY = 4096,
  parameter int unsigned MIN_DELAY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] sample_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      sample_out_o
);

  localparam int unsigned AW   = $clog2(MAX_DELAY);
  localparam int unsigned DW   = $clog2(MAX_DELAY + 1);
  localparam int unsigned SPAN = MAX_DELAY - MIN_DELAY;

  // Configuration registers.
  logic [7:0]         time_knob_q, feedback_knob_q, mix_knob_q;
  logic signed [15:0] clamp_high_q, clamp_low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_knob_q     <= '0;
      feedback_knob_q <= '0;
      mix_knob_q      <= '0;
      clamp_high_q    <= 16'sh7fff;
      clamp_low_q     <= 16'sh8000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fdm_pkg::CFG_TIME_KNOB:     time_knob_q     <= cfg_wdata_i[7:0];
        fdm_pkg::CFG_FEEDBACK_KNOB: feedback_knob_q <= cfg_wdata_i[7:0];
        fdm_pkg::CFG_MIX_KNOB:      mix_knob_q      <= cfg_wdata_i[7:0];
        fdm_pkg::CFG_CLAMP_HIGH:    clamp_high_q    <= cfg_wdata_i;
        fdm_pkg::CFG_CLAMP_LOW:     clamp_low_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath state.
  fdm_pkg::state_e    state_q, state_d;
  logic [AW-1:0]      wp_q, wp_d;
  logic               full_q, full_d;
  logic signed [15:0] prev_tap_q, prev_tap_d;
  logic signed [15:0] last_wet_q, last_wet_d;
  logic               out_valid_q, out_valid_d;
  logic               rd_valid_q, rd_valid_d;
  logic signed [15:0] x_q, x_d;
  logic [DW-1:0]      d_q, d_d;
  logic [7:0]         frac_q, frac_d;
  logic signed [15:0] tap_q, tap_d;
  logic signed [15:0] out_q, out_d;

  // Shared unit and store connections.
  fdm_pkg::mul_ctrl_t                   mul_ctrl;
  logic signed [fdm_pkg::A_W-1:0]       mul_a;
  logic signed [fdm_pkg::B_W-1:0]       mul_b;
  logic        [fdm_pkg::V_W-1:0]       mul_num;
  logic signed [fdm_pkg::P_W-1:0]       prod;
  logic        [fdm_pkg::V_W-1:0]       num;
  logic        [fdm_pkg::Q_W-1:0]       quot;
  logic                                 st_we, st_re;
  logic [AW-1:0]                        rd_addr;
  logic [15:0]                          st_rdata;
  logic signed [15:0]                   st_wdata;

  // Helper values.
  logic signed [fdm_pkg::Q_W:0]         qs;
  logic        [fdm_pkg::V_W-1:0]       len;
  logic signed [18:0]                   w;
  logic signed [18:0]                   chi, clo;
  logic [DW:0]                          wpx, dx, rdiff, rwrap;
  logic signed [15:0]                   tap_now;
  logic signed [16:0]                   tap_diff;
  logic signed [25:0]                   wsum;
  logic signed [19:0]                   y;
  logic signed [15:0]                   mix_base;

  fdm_mul_unit u_mul (
    .clk_i  (clk_i),
    .ctrl_i (mul_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .num_i  (mul_num),
    .prod_o (prod),
    .num_o  (num),
    .quot_o (quot)
  );

  fdm_store #(
    .DEPTH (MAX_DELAY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (wp_q),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (rd_addr),
    .rdata_o (st_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdm_pkg::ST_IDLE;
      wp_q        <= '0;
      full_q      <= 1'b0;
      prev_tap_q  <= '0;
      last_wet_q  <= '0;
      out_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      full_q      <= full_d;
      prev_tap_q  <= prev_tap_d;
      last_wet_q  <= last_wet_d;
      out_valid_q <= out_valid_d;
      rd_valid_q  <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    d_q    <= d_d;
    frac_q <= frac_d;
    tap_q  <= tap_d;
    out_q  <= out_d;
  end

  // Arithmetic shared by several steps.
  always_comb begin
    // Divide result with the bias removed, for the signed rounded divisions.
    qs    = $signed({1'b0, quot}) - $signed((fdm_pkg::Q_W + 1)'(fdm_pkg::RDIV_BIAS));
    // Delay length with an eight-bit fraction: MIN*256 + P + floor(P/255).
    len   = fdm_pkg::V_W'(MIN_DELAY * 256) + num + fdm_pkg::V_W'(quot);
    // Sample plus feedback, then the clamp with the upper limit tested first.
    w     = $signed({{3{x_q[15]}}, x_q}) + qs;
    chi   = $signed({{3{clamp_high_q[15]}}, clamp_high_q});
    clo   = $signed({{3{clamp_low_q[15]}}, clamp_low_q});
    if (w > chi) begin
      st_wdata = clamp_high_q;
    end else if (w < clo) begin
      st_wdata = clamp_low_q;
    end else begin
      st_wdata = w[15:0];
    end
    // Read position d entries behind the advanced write position.
    wpx   = (DW + 1)'(wp_q);
    dx    = (DW + 1)'(d_q);
    rdiff = wpx - dx;
    rwrap = rdiff + (DW + 1)'(MAX_DELAY);
    if (wpx >= dx) begin
      rd_addr = rdiff[AW-1:0];
    end else begin
      rd_addr = rwrap[AW-1:0];
    end
    // An entry never written since reset reads as zero.
    tap_now  = rd_valid_q ? $signed(st_rdata) : 16'sd0;
    tap_diff = $signed({prev_tap_q[15], prev_tap_q}) - $signed({tap_now[15], tap_now});
    // Blend: (tap*256 + (prev - tap)*frac + 128) >> 8.
    wsum     = $signed({{2{tap_q[15]}}, tap_q, 8'd0}) + $signed(prod[25:0]) + 26'sd128;
    mix_base = (mix_knob_q < 8'd128) ? x_q : last_wet_q;
    y        = $signed({{4{mix_base[15]}}, mix_base}) + $signed({qs[fdm_pkg::Q_W], qs});
  end

  // Sequencer: next state, unit operands and register updates.
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    full_d      = full_q;
    prev_tap_d  = prev_tap_q;
    last_wet_d  = last_wet_q;
    out_valid_d = out_valid_q;
    rd_valid_d  = rd_valid_q;
    x_d         = x_q;
    d_d         = d_q;
    frac_d      = frac_q;
    tap_d       = tap_q;
    out_d       = out_q;
    mul_ctrl    = '0;
    mul_a       = '0;
    mul_b       = '0;
    mul_num     = '0;
    st_we       = 1'b0;
    st_re       = 1'b0;
    in_stall_o  = 1'b1;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      fdm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          x_d     = sample_in_i;
          state_d = fdm_pkg::ST_LEN_MUL;
        end
      end
      fdm_pkg::ST_LEN_MUL: begin
        mul_ctrl.mul_en = 1'b1;
        mul_a   = $signed(fdm_pkg::A_W'(time_knob_q));
        mul_b   = $signed(fdm_pkg::B_W'(SPAN));
        state_d = fdm_pkg::ST_LEN_DIV;
      end
      fdm_pkg::ST_LEN_DIV: begin
        mul_ctrl.mul_en   = 1'b1;
        mul_ctrl.num_load = 1'b1;
        mul_num = prod[fdm_pkg::V_W-1:0];
        mul_a   = $signed({1'b0, mul_num});
        mul_b   = $signed({1'b0, fdm_pkg::RECIP});
        state_d = fdm_pkg::ST_LEN_FIX;
      end
      fdm_pkg::ST_LEN_FIX: begin
        d_d    = len[8 +: DW];
        frac_d = len[7:0];
        // Feedback term: feedback_knob * last_wet.
        mul_ctrl.mul_en = 1'b1;
        mul_a   = $signed({{(fdm_pkg::A_W - 16){last_wet_q[15]}}, last_wet_q});
        mul_b   = $signed(fdm_pkg::B_W'(feedback_knob_q));
        state_d = fdm_pkg::ST_FB_DIV;
      end
      fdm_pkg::ST_FB_DIV: begin
        mul_ctrl.mul_en   = 1'b1;
        mul_ctrl.num_load = 1'b1;
        mul_num = prod[fdm_pkg::V_W-1:0] + fdm_pkg::RDIV_OFS;
        mul_a   = $signed({1'b0, mul_num});
        mul_b   = $signed({1'b0, fdm_pkg::RECIP});
        state_d = fdm_pkg::ST_FB_FIX;
      end
      fdm_pkg::ST_FB_FIX: begin
        st_we = 1'b1;
        if (wp_q == AW'(MAX_DELAY - 1)) begin
          wp_d   = '0;
          full_d = 1'b1;
        end else begin
          wp_d = wp_q + 1'b1;
        end
        state_d = fdm_pkg::ST_RD;
      end
      fdm_pkg::ST_RD: begin
        st_re      = 1'b1;
        rd_valid_d = full_q || (rd_addr < wp_q);
        state_d    = fdm_pkg::ST_TAP;
      end
      fdm_pkg::ST_TAP: begin
        tap_d = tap_now;
        mul_ctrl.mul_en = 1'b1;
        mul_a   = $signed({{(fdm_pkg::A_W - 17){tap_diff[16]}}, tap_diff});
        mul_b   = $signed(fdm_pkg::B_W'(frac_q));
        state_d = fdm_pkg::ST_WET;
      end
      fdm_pkg::ST_WET: begin
        prev_tap_d = tap_q;
        last_wet_d = wsum[23:8];
        state_d    = fdm_pkg::ST_MIX_MUL;
      end
      fdm_pkg::ST_MIX_MUL: begin
        mul_ctrl.mul_en = 1'b1;
        if (mix_knob_q < 8'd128) begin
          mul_a = $signed({{(fdm_pkg::A_W - 16){last_wet_q[15]}}, last_wet_q});
          mul_b = $signed(fdm_pkg::B_W'({mix_knob_q, 1'b0}));
        end else begin
          mul_a = $signed({{(fdm_pkg::A_W - 16){x_q[15]}}, x_q});
          mul_b = $signed(fdm_pkg::B_W'({8'd255 - mix_knob_q, 1'b0}));
        end
        state_d = fdm_pkg::ST_MIX_DIV;
      end
      fdm_pkg::ST_MIX_DIV: begin
        mul_ctrl.mul_en   = 1'b1;
        mul_ctrl.num_load = 1'b1;
        mul_num = prod[fdm_pkg::V_W-1:0] + fdm_pkg::RDIV_OFS;
        mul_a   = $signed({1'b0, mul_num});
        mul_b   = $signed({1'b0, fdm_pkg::RECIP});
        state_d = fdm_pkg::ST_MIX_FIX;
      end
      fdm_pkg::ST_MIX_FIX: begin
        // Hold here until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          if (y > 20'sd32767) begin
            out_d = 16'sh7fff;
          end else if (y < -20'sd32768) begin
            out_d = 16'sh8000;
          end else begin
            out_d = y[15:0];
          end
          out_valid_d = 1'b1;
          state_d     = fdm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fdm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

endmodule

`default_nettype wire
